@@ src/wsb_pkg.sv @@
// Shared types and constants of the warp register scoreboard.
package wsb_pkg;

	localparam int REQ_W       = 3;
	localparam int WARP_W      = 6;
	localparam int REG_W       = 8;
	localparam int INPUT_SLOTS = 4;
	// Each lane covers one 64-bit slice of a warp's register bitmap
	localparam int LANE_W      = 64;
	localparam int LANE_AW     = 6;

	typedef enum logic [REQ_W-1:0] {
		REQ_RESERVE = 3'd0,
		REQ_RELEASE = 3'd1,
		REQ_CHECK   = 3'd2,
		REQ_PENDING = 3'd3,
		REQ_LONGOP  = 3'd4
	} req_code_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LANE  = 3'b010,
		ST_MERGE = 3'b100
	} state_t;

	typedef struct packed {
		logic [REQ_W-1:0]                    req_type;
		logic [WARP_W-1:0]                   warp_id;
		logic [INPUT_SLOTS-1:0][REG_W-1:0]   reg_slot;
		logic [REG_W-1:0]                    pred_reg;
		logic [REG_W-1:0]                    addr_reg_one;
		logic [REG_W-1:0]                    addr_reg_two;
		logic                                is_load;
	} sb_req_t;

	typedef struct packed {
		logic collision;
		logic pending_writes;
		logic long_op;
		logic double_reserve;
	} sb_rsp_t;

	// What one lane found in its slice
	typedef struct packed {
		logic rsv_hit;   // instruction slot hits a reserved bit
		logic chk_hit;   // any checked register hits a reserved bit
		logic any;       // slice holds a reserved bit
		logic lop_hit;   // slot0 hits a long-op bit
	} lane_flags_t;

endpackage

@@ src/wsb_if.sv @@
// Request and response channel interfaces of the warp register scoreboard.
interface sb_req_if;
	logic                           valid;
	logic                           ready;
	logic [wsb_pkg::REQ_W-1:0]      req_type;
	logic [wsb_pkg::WARP_W-1:0]     warp_id;
	logic [wsb_pkg::REG_W-1:0]      reg_slot0;
	logic [wsb_pkg::REG_W-1:0]      reg_slot1;
	logic [wsb_pkg::REG_W-1:0]      reg_slot2;
	logic [wsb_pkg::REG_W-1:0]      reg_slot3;
	logic [wsb_pkg::REG_W-1:0]      pred_reg;
	logic [wsb_pkg::REG_W-1:0]      addr_reg_one;
	logic [wsb_pkg::REG_W-1:0]      addr_reg_two;
	logic                           is_load;

	modport source (
		output valid, req_type, warp_id, reg_slot0, reg_slot1, reg_slot2, reg_slot3,
		       pred_reg, addr_reg_one, addr_reg_two, is_load,
		input  ready
	);
	modport sink (
		input  valid, req_type, warp_id, reg_slot0, reg_slot1, reg_slot2, reg_slot3,
		       pred_reg, addr_reg_one, addr_reg_two, is_load,
		output ready
	);
endinterface

interface sb_rsp_if;
	logic valid;
	logic ready;
	logic collision;
	logic pending_writes;
	logic long_op;
	logic double_reserve;

	modport source (
		output valid, collision, pending_writes, long_op, double_reserve,
		input  ready
	);
	modport sink (
		input  valid, collision, pending_writes, long_op, double_reserve,
		output ready
	);
endinterface

@@ src/wsb_lane.sv @@
// One lane: decodes request registers into its 64-bit slice and tests the slice.
module wsb_lane #(
	parameter int LANE_IDX = 0,
	parameter int NUM_REGS = 256,
	parameter int SLOTS    = 4
) (
	input  logic                         clk,
	input  logic                         en,
	input  wsb_pkg::sb_req_t             req,
	input  logic [wsb_pkg::LANE_W-1:0]   rsv_word,
	input  logic [wsb_pkg::LANE_W-1:0]   lop_word,
	output logic [wsb_pkg::LANE_W-1:0]   mask_s2,
	output wsb_pkg::lane_flags_t         flags_s2
);

	logic [wsb_pkg::LANE_W-1:0] slot_mask;
	logic [wsb_pkg::LANE_W-1:0] chk_mask;
	logic [wsb_pkg::LANE_W-1:0] qry_mask;
	wsb_pkg::lane_flags_t       flags;

	// Register belongs here: nonzero, in range, upper bits select this lane
	function automatic logic in_lane(input logic [wsb_pkg::REG_W-1:0] r);
		logic ok;
		ok = (r != '0) && (int'(r) < NUM_REGS)
			&& (int'(r[wsb_pkg::REG_W-1:wsb_pkg::LANE_AW]) == LANE_IDX);
		return ok;
	endfunction

	// Build bit masks of the listed registers
	always_comb begin
		slot_mask = '0;
		chk_mask  = '0;
		qry_mask  = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (in_lane(req.reg_slot[i])) begin
				slot_mask[req.reg_slot[i][wsb_pkg::LANE_AW-1:0]] = 1'b1;
			end
		end
		if (in_lane(req.pred_reg)) begin
			chk_mask[req.pred_reg[wsb_pkg::LANE_AW-1:0]] = 1'b1;
		end
		if (in_lane(req.addr_reg_one)) begin
			chk_mask[req.addr_reg_one[wsb_pkg::LANE_AW-1:0]] = 1'b1;
		end
		if (in_lane(req.addr_reg_two)) begin
			chk_mask[req.addr_reg_two[wsb_pkg::LANE_AW-1:0]] = 1'b1;
		end
		if (in_lane(req.reg_slot[0])) begin
			qry_mask[req.reg_slot[0][wsb_pkg::LANE_AW-1:0]] = 1'b1;
		end
	end

	// Slice tests
	always_comb begin
		flags.rsv_hit = |(slot_mask & rsv_word);
		flags.chk_hit = |((slot_mask | chk_mask) & rsv_word);
		flags.any     = |rsv_word;
		flags.lop_hit = |(qry_mask & lop_word);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s2  <= slot_mask;
			flags_s2 <= flags;
		end
	end

endmodule

@@ src/wsb_merge.sv @@
// Merge stage: combines lane flags into the result and forms the row write-back.
module wsb_merge #(
	parameter int NUM_LANES = 4,
	parameter int NUM_WARPS = 64
) (
	input  logic                                   fire,
	input  wsb_pkg::sb_req_t                       req,
	input  logic [NUM_LANES*wsb_pkg::LANE_W-1:0]   rsv_row,
	input  logic [NUM_LANES*wsb_pkg::LANE_W-1:0]   lop_row,
	input  logic [NUM_LANES*wsb_pkg::LANE_W-1:0]   mask_row,
	input  wsb_pkg::lane_flags_t [NUM_LANES-1:0]   flags,
	output wsb_pkg::sb_rsp_t                       rsp,
	output logic                                   wr_en,
	output logic [NUM_LANES*wsb_pkg::LANE_W-1:0]   wr_rsv,
	output logic [NUM_LANES*wsb_pkg::LANE_W-1:0]   wr_lop
);

	wsb_pkg::lane_flags_t all;
	logic                 warp_ok;
	logic                 is_rsv;
	logic                 is_rel;
	logic                 dbl;

	// OR the lane flags together
	always_comb begin
		all = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			all = all | flags[i];
		end
	end

	assign warp_ok = int'(req.warp_id) < NUM_WARPS;
	assign is_rsv  = warp_ok && (req.req_type == wsb_pkg::REQ_RESERVE);
	assign is_rel  = warp_ok && (req.req_type == wsb_pkg::REQ_RELEASE);
	assign dbl     = is_rsv && all.rsv_hit;

	// Result fields, zero unless they belong to the request
	always_comb begin
		rsp.collision      = warp_ok && (req.req_type == wsb_pkg::REQ_CHECK) && all.chk_hit;
		rsp.pending_writes = warp_ok && (req.req_type == wsb_pkg::REQ_PENDING) && all.any;
		rsp.long_op        = warp_ok && (req.req_type == wsb_pkg::REQ_LONGOP) && all.lop_hit;
		rsp.double_reserve = dbl;
	end

	// Row write-back: reserve sets reserved bits (long-op bits too for a load), release clears both maps
	always_comb begin
		wr_en  = fire && ((is_rsv && !dbl) || is_rel);
		wr_rsv = is_rsv ? (rsv_row | mask_row) : (rsv_row & ~mask_row);
		if (is_rsv) begin
			wr_lop = req.is_load ? (lop_row | mask_row) : lop_row;
		end else begin
			wr_lop = lop_row & ~mask_row;
		end
	end

endmodule

@@ src/warp_register_scoreboard.sv @@
// Top level of the per-warp register scoreboard.
//
//   channel  dir   interface        content of one beat
//   req      in    sb_req_if.sink   request code, warp, slot/pred/addr registers, load flag
//   rsp      out   sb_rsp_if.source collision, pending_writes, long_op, double_reserve
//
// A request passes three steps: warp row read from the bitmap memories, lane
// decode and test, merge with row write-back into the output register.
// A new request is taken once the previous one has left the merge stage.
// Reset clears one row-valid flop per warp; an unwritten row reads as all clear.
// A stalled rsp holds its beat; merge waits while the output register is full.
module warp_register_scoreboard #(
	parameter int NUM_WARPS = 64,
	parameter int NUM_REGS  = 256,
	parameter int REG_SLOTS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	sb_req_if.sink         req,
	sb_rsp_if.source       rsp
);

	localparam int NUM_LANES = (NUM_REGS + wsb_pkg::LANE_W - 1) / wsb_pkg::LANE_W;
	localparam int ROW_W     = NUM_LANES * wsb_pkg::LANE_W;
	localparam int WARP_AW   = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
	localparam int SLOTS     = (REG_SLOTS < wsb_pkg::INPUT_SLOTS) ? REG_SLOTS
	                                                              : wsb_pkg::INPUT_SLOTS;

	wsb_pkg::state_t                       state_q;
	wsb_pkg::sb_req_t                      req_in;
	wsb_pkg::sb_req_t                      req_s1;
	logic [ROW_W-1:0]                      mem_rsv [NUM_WARPS];
	logic [ROW_W-1:0]                      mem_lop [NUM_WARPS];
	logic [NUM_WARPS-1:0]                  row_vld_q;
	logic [ROW_W-1:0]                      rd_rsv_q;
	logic [ROW_W-1:0]                      rd_lop_q;
	logic [ROW_W-1:0]                      mask_s2;
	wsb_pkg::lane_flags_t [NUM_LANES-1:0]  flags_s2;
	wsb_pkg::sb_rsp_t                      rsp_d;
	wsb_pkg::sb_rsp_t                      rsp_q;
	logic                                  out_valid_q;
	logic                                  in_fire;
	logic                                  merge_fire;
	logic                                  wr_en;
	logic [ROW_W-1:0]                      wr_rsv;
	logic [ROW_W-1:0]                      wr_lop;
	logic [WARP_AW-1:0]                    rd_addr;
	logic [WARP_AW-1:0]                    wr_addr;

	// Input beat into a request struct
	always_comb begin
		req_in.req_type     = req.req_type;
		req_in.warp_id      = req.warp_id;
		req_in.reg_slot[0]  = req.reg_slot0;
		req_in.reg_slot[1]  = req.reg_slot1;
		req_in.reg_slot[2]  = req.reg_slot2;
		req_in.reg_slot[3]  = req.reg_slot3;
		req_in.pred_reg     = req.pred_reg;
		req_in.addr_reg_one = req.addr_reg_one;
		req_in.addr_reg_two = req.addr_reg_two;
		req_in.is_load      = req.is_load;
	end

	assign req.ready  = (state_q == wsb_pkg::ST_IDLE);
	assign in_fire    = req.valid && req.ready;
	assign merge_fire = (state_q == wsb_pkg::ST_MERGE) && (!out_valid_q || rsp.ready);
	assign rd_addr    = req.warp_id[WARP_AW-1:0];
	assign wr_addr    = req_s1.warp_id[WARP_AW-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsb_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				wsb_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= wsb_pkg::ST_LANE;
					end
				end
				wsb_pkg::ST_LANE: begin
					state_q <= wsb_pkg::ST_MERGE;
				end
				wsb_pkg::ST_MERGE: begin
					if (merge_fire) begin
						state_q <= wsb_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wsb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Request register and registered row read; a row never written reads as clear
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1   <= req_in;
			rd_rsv_q <= row_vld_q[rd_addr] ? mem_rsv[rd_addr] : '0;
			rd_lop_q <= row_vld_q[rd_addr] ? mem_lop[rd_addr] : '0;
		end
	end

	// Bitmap memories, one row per warp
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_rsv[wr_addr] <= wr_rsv;
			mem_lop[wr_addr] <= wr_lop;
		end
	end

	// Row-valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Lanes, one per 64-bit slice of the row
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		wsb_lane #(
			.LANE_IDX (g),
			.NUM_REGS (NUM_REGS),
			.SLOTS    (SLOTS)
		) u_lane (
			.clk      (clk),
			.en       (state_q == wsb_pkg::ST_LANE),
			.req      (req_s1),
			.rsv_word (rd_rsv_q[g*wsb_pkg::LANE_W +: wsb_pkg::LANE_W]),
			.lop_word (rd_lop_q[g*wsb_pkg::LANE_W +: wsb_pkg::LANE_W]),
			.mask_s2  (mask_s2[g*wsb_pkg::LANE_W +: wsb_pkg::LANE_W]),
			.flags_s2 (flags_s2[g])
		);
	end

	wsb_merge #(
		.NUM_LANES (NUM_LANES),
		.NUM_WARPS (NUM_WARPS)
	) u_merge (
		.fire     (merge_fire),
		.req      (req_s1),
		.rsv_row  (rd_rsv_q),
		.lop_row  (rd_lop_q),
		.mask_row (mask_s2),
		.flags    (flags_s2),
		.rsp      (rsp_d),
		.wr_en    (wr_en),
		.wr_rsv   (wr_rsv),
		.wr_lop   (wr_lop)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (merge_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (merge_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.collision      = rsp_q.collision;
	assign rsp.pending_writes = rsp_q.pending_writes;
	assign rsp.long_op        = rsp_q.long_op;
	assign rsp.double_reserve = rsp_q.double_reserve;

`ifndef SYNTHESIS
	// At most one result field is set in a beat
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $countones({rsp.collision, rsp.pending_writes,
		                          rsp.long_op, rsp.double_reserve}) <= 1)
		else $error("more than one result field set");

	// Row write-back happens only as the merge stage hands off
	a_wr_merge: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == wsb_pkg::ST_MERGE) && merge_fire)
		else $error("row written outside merge");

	// An accepted request moves to the lane stage
	a_accept_lane: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == wsb_pkg::ST_LANE))
		else $error("accepted request did not enter lane stage");

	// A new output beat comes only from the merge stage
	a_out_from_merge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> ($past(state_q) == wsb_pkg::ST_MERGE))
		else $error("output beat without merge");

	// A written row is marked valid
	a_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> row_vld_q[$past(wr_addr)])
		else $error("written row not marked valid");
`endif

endmodule
